// ===== rtl/ecal_pkg.sv =====
package ecal_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned DayWidth  = 16;
  localparam int unsigned TodWidth  = 17;

  // seconds from 1901-01-01 to the epoch
  localparam logic [32:0] EpochBias = 33'd2177452800;

  // reciprocals; each is exact over the full range of its dividend
  localparam logic [26:0] Recip675  = 27'd101806633;  // shift 36, dividend < 2^26
  localparam logic [17:0] Recip60   = 18'd139811;     // shift 23, dividend < 86400
  localparam logic [11:0] Recip60m  = 12'd2185;       // shift 17, dividend < 1440
  localparam logic [16:0] Recip1461 = 17'd91868;      // shift 27, dividend < 2^16
  localparam logic [16:0] Recip7    = 17'd74899;      // shift 19, dividend < 2^16 + 2

  localparam logic [8:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  localparam logic [3:0] LastMonth = 4'd11;
  localparam logic [2:0] EpochWeekdayOffset = 3'd2;  // day 0 of 1901 count is a tuesday

  typedef struct packed {
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
  } date_t;

  function automatic logic [8:0] first_day(input logic [3:0] mon, input logic leap);
    logic [8:0] base;
    base = MonthStart[mon];
    return base + {8'd0, (leap && (mon > 4'd1))};
  endfunction

endpackage

// ===== rtl/ecal_date.sv =====
module ecal_date
  import ecal_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                day_valid,
  input  logic [DayWidth-1:0] day_count,
  output logic                date_valid,
  output date_t               date
);

  // stage 1: quotients by 1461 and by 7
  logic [32:0] quad_prod;
  logic [16:0] wk_num;
  logic [33:0] wk_prod;
  logic        v1_r;
  logic [DayWidth-1:0] days1_r;
  logic [5:0]  quad1_r;
  logic [12:0] wq1_r;

  assign quad_prod = 33'(day_count) * 33'(Recip1461);
  assign wk_num    = 17'(day_count) + 17'(EpochWeekdayOffset);
  assign wk_prod   = 34'(wk_num) * 34'(Recip7);

  // stage 2: remainders
  logic [16:0] quad_x;
  logic [15:0] wq_x;
  logic [16:0] wk_num1;
  logic        v2_r;
  logic [10:0] rest2_r;
  logic [5:0]  quad2_r;
  logic [2:0]  wday2_r;

  assign quad_x  = 17'(quad1_r) * 17'd1461;
  assign wq_x    = 16'(wq1_r) * 16'd7;
  assign wk_num1 = 17'(days1_r) + 17'(EpochWeekdayOffset);

  // stage 3: year within the four-year cycle
  logic [1:0]  yin;
  logic        v3_r;
  logic [8:0]  yday3_r;
  logic        leap3_r;
  logic [7:0]  year3_r;
  logic [2:0]  wday3_r;

  always_comb begin
    if (rest2_r >= 11'd1095) begin
      yin = 2'd3;
    end else if (rest2_r >= 11'd730) begin
      yin = 2'd2;
    end else if (rest2_r >= 11'd365) begin
      yin = 2'd1;
    end else begin
      yin = 2'd0;
    end
  end

  logic [10:0] yin_off;
  always_comb begin
    case (yin)
      2'd1:    yin_off = 11'd365;
      2'd2:    yin_off = 11'd730;
      2'd3:    yin_off = 11'd1095;
      default: yin_off = 11'd0;
    endcase
  end

  // stage 4: month search over the cumulative table
  logic [3:0] mon;
  logic [8:0] mon_start;
  logic [8:0] dom_full;
  logic       v4_r;
  date_t      date4_r;

  always_comb begin
    mon = 4'd0;
    for (int i = 1; i <= 11; i++) begin
      if (yday3_r >= first_day(4'(i), leap3_r)) mon = mon + 4'd1;
    end
  end

  assign mon_start = first_day(mon, leap3_r);
  assign dom_full  = yday3_r - mon_start + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= day_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    days1_r <= day_count;
    quad1_r <= quad_prod[32:27];
    wq1_r   <= wk_prod[31:19];

    rest2_r <= days1_r[10:0] - quad_x[10:0];
    quad2_r <= quad1_r;
    wday2_r <= wk_num1[2:0] - wq_x[2:0];

    yday3_r <= 9'(rest2_r - yin_off);
    leap3_r <= (yin == 2'd3);
    year3_r <= 8'd1 + {quad2_r, 2'b00} + 8'(yin);
    wday3_r <= wday2_r;

    date4_r.day_of_month     <= dom_full[4:0];
    date4_r.month            <= mon;
    date4_r.years_since_1900 <= year3_r;
    date4_r.weekday          <= wday3_r;
    date4_r.day_of_year      <= yday3_r;
  end

  assign date_valid = v4_r;
  assign date       = date4_r;

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (date4_r.month <= LastMonth))
    else $error("month out of range");

  a_yday_leap: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !leap3_r) |-> (yday3_r < 9'd365))
    else $error("day of year past end of common year");

  a_dom_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (date4_r.day_of_month != 5'd0 && date4_r.weekday < 3'd7))
    else $error("day of month or weekday out of range");

endmodule

// ===== rtl/epoch_seconds_to_calendar_core.sv =====
// channel   | ports                                    | direction
// ----------+------------------------------------------+--------------------
// input     | start, busy, in_seconds                  | in (busy out)
// result    | out_valid, out_second .. out_day_of_year | out
//
// fully pipelined: one timestamp accepted every cycle, busy is never raised;
// each result passes through the registered stages of the reciprocal
//   multiplier chain (seconds to days, days to four-year cycles, months)
// synchronous active-low reset clears the valid bits only
// results are shown for a single cycle and the receiver cannot stall them
module epoch_seconds_to_calendar_core
  import ecal_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [TimeWidth-1:0] in_seconds,
  output logic                 out_valid,
  output logic [5:0]           out_second,
  output logic [5:0]           out_minute,
  output logic [4:0]           out_hour,
  output logic [4:0]           out_day_of_month,
  output logic [3:0]           out_month,
  output logic [7:0]           out_years_since_1900,
  output logic [2:0]           out_weekday,
  output logic [8:0]           out_day_of_year
);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: rebias to seconds since 1901, always positive
  logic [32:0] total_nxt;
  logic        v1_r;
  logic [32:0] total1_r;

  assign total_nxt = {in_seconds[TimeWidth-1], in_seconds} + EpochBias;

  // stage 2: days = total / 86400, as (total >> 7) / 675
  logic [52:0] day_prod;
  logic        v2_r;
  logic [DayWidth-1:0] days2_r;
  logic [9:0]  q1lo2_r;
  logic [6:0]  low2_r;

  assign day_prod = 53'(total1_r[32:7]) * 53'(Recip675);

  // stage 3: time of day
  logic [25:0] day_x;
  logic        v3_r;
  logic [DayWidth-1:0] days3_r;
  logic [TodWidth-1:0] tod3_r;

  assign day_x = 26'(days2_r) * 26'd675;

  // time of day branch, four stages to line up with the date unit
  logic [34:0] min_prod;
  logic [10:0] mins_t1_r;
  logic [TodWidth-1:0] tod_t1_r;

  assign min_prod = 35'(tod3_r) * 35'(Recip60);

  logic [22:0] hour_prod;
  logic [16:0] mins_x60;
  logic [10:0] mins_t2_r;
  logic [4:0]  hour_t2_r;
  logic [5:0]  sec_t2_r;

  assign hour_prod = 23'(mins_t1_r) * 23'(Recip60m);
  assign mins_x60  = 17'(mins_t1_r) * 17'd60;

  logic [10:0] hour_x60;
  logic [5:0]  min_t3_r;
  logic [4:0]  hour_t3_r;
  logic [5:0]  sec_t3_r;

  assign hour_x60 = 11'(hour_t2_r) * 11'd60;

  logic [5:0]  min_t4_r;
  logic [4:0]  hour_t4_r;
  logic [5:0]  sec_t4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    total1_r <= total_nxt;

    days2_r <= day_prod[51:36];
    q1lo2_r <= total1_r[16:7];
    low2_r  <= total1_r[6:0];

    days3_r <= days2_r;
    tod3_r  <= {q1lo2_r - day_x[9:0], low2_r};

    mins_t1_r <= min_prod[33:23];
    tod_t1_r  <= tod3_r;

    mins_t2_r <= mins_t1_r;
    hour_t2_r <= hour_prod[21:17];
    sec_t2_r  <= tod_t1_r[5:0] - mins_x60[5:0];

    min_t3_r  <= mins_t2_r[5:0] - hour_x60[5:0];
    hour_t3_r <= hour_t2_r;
    sec_t3_r  <= sec_t2_r;

    min_t4_r  <= min_t3_r;
    hour_t4_r <= hour_t3_r;
    sec_t4_r  <= sec_t3_r;
  end

  logic  date_valid;
  date_t date;

  ecal_date u_date (
    .clk        (clk),
    .rst_n      (rst_n),
    .day_valid  (v3_r),
    .day_count  (days3_r),
    .date_valid (date_valid),
    .date       (date)
  );

  assign out_valid            = date_valid;
  assign out_second           = sec_t4_r;
  assign out_minute           = min_t4_r;
  assign out_hour             = hour_t4_r;
  assign out_day_of_month     = date.day_of_month;
  assign out_month            = date.month;
  assign out_years_since_1900 = date.years_since_1900;
  assign out_weekday          = date.weekday;
  assign out_day_of_year      = date.day_of_year;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##7 out_valid)
    else $error("transaction lost in pipeline");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> $past(v2_r))
    else $error("valid appeared without a transaction");

  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_second < 6'd60 && out_minute < 6'd60 && out_hour < 5'd24))
    else $error("time of day out of range");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import ecal_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned RandomItems = 1130;
  localparam int unsigned DrainCycles = 16;
  localparam longint EpochOffsetSecs = 64'sd2177452800;  // 1901-01-01 to the epoch
  localparam int unsigned DaysPerQuad = 1461;
  localparam int unsigned DaysToEpoch = 25202;

  localparam int unsigned CumDays [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
  } cal_time_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [TimeWidth-1:0] in_seconds = '0;
  logic                 out_valid;
  logic [5:0]           out_second;
  logic [5:0]           out_minute;
  logic [4:0]           out_hour;
  logic [4:0]           out_day_of_month;
  logic [3:0]           out_month;
  logic [7:0]           out_years_since_1900;
  logic [2:0]           out_weekday;
  logic [8:0]           out_day_of_year;

  cal_time_t   pending_dates [$];
  int unsigned mismatches = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_before_epoch = 0;
  int unsigned n_leap_dec31 = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;

  epoch_seconds_to_calendar_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_seconds          (in_seconds),
    .out_valid           (out_valid),
    .out_second          (out_second),
    .out_minute          (out_minute),
    .out_hour            (out_hour),
    .out_day_of_month    (out_day_of_month),
    .out_month           (out_month),
    .out_years_since_1900(out_years_since_1900),
    .out_weekday         (out_weekday),
    .out_day_of_year     (out_day_of_year)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned month_offset(input int unsigned mon, input bit leap);
    return CumDays[mon] + ((leap && mon > 1) ? 1 : 0);
  endfunction

  function automatic cal_time_t to_calendar(input logic [TimeWidth-1:0] secs);
    longint      total;
    int unsigned days;
    int unsigned tod;
    int unsigned rest;
    int unsigned yin;
    int unsigned yday;
    int unsigned mon;
    bit          leap;
    cal_time_t   cal;
    // counting from 1901 keeps everything positive, so division floors
    total = longint'($signed(secs)) + EpochOffsetSecs;
    days = int'(total / 86400);
    tod = int'(total % 86400);
    rest = days % DaysPerQuad;
    yin = rest / 365;
    if (yin > 3) yin = 3;  // last day of a leap year stays in that year
    yday = rest - yin * 365;
    leap = (yin == 3);
    mon = 0;
    while (mon < 11 && yday >= month_offset(mon + 1, leap)) mon++;
    cal.second = 6'(tod % 60);
    cal.minute = 6'((tod / 60) % 60);
    cal.hour = 5'(tod / 3600);
    cal.day_of_month = 5'(yday - month_offset(mon, leap) + 1);
    cal.month = 4'(mon);
    cal.years_since_1900 = 8'(1 + 4 * (days / DaysPerQuad) + yin);
    cal.weekday = 3'((days + 2) % 7);
    cal.day_of_year = 9'(yday);
    return cal;
  endfunction

  // sender runs in bursts; a zero gap keeps start high into the next burst
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_time(input logic [TimeWidth-1:0] secs);
    cal_time_t cal;
    start <= 1'b1;
    in_seconds <= secs;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    cal = to_calendar(secs);
    pending_dates.push_back(cal);
    n_sent++;
    if (secs[TimeWidth-1]) n_before_epoch++;
    if (cal.day_of_year == 9'd365) n_leap_dec31++;
    pace();
  endtask

  task automatic test_day_boundaries();
    logic [TimeWidth-1:0] stamps [] = '{
      0, 1, -1, 59, 3599, 3600, 86399, 86400, -86400, -86401
    };
    foreach (stamps[i]) send_time(stamps[i]);
  endtask

  task automatic test_range_extremes();
    logic [TimeWidth-1:0] stamps [] = '{
      32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
    };
    foreach (stamps[i]) send_time(stamps[i]);
  endtask

  // leap day, the day after, december and the last day of leap years
  task automatic test_leap_and_december();
    logic [TimeWidth-1:0] stamps [] = '{
      68169600, 68256000, 94521600, 94607999, 28857600, 31449600, -31622400,
      951782400
    };
    foreach (stamps[i]) send_time(stamps[i]);
  endtask

  task automatic test_random_times(input int unsigned count);
    longint      stamp;
    int          day_no;
    int unsigned day_in_quad [] = '{
      0, 364, 365, 729, 730, 1094, 1095, 1153, 1154, 1155, 1429, 1460
    };
    repeat (count) begin
      case ($urandom_range(0, 9))
        6, 7: begin
          // just either side of midnight
          day_no = int'($urandom_range(0, 49710)) - 24855;
          stamp = longint'(day_no) * 86400;
          case ($urandom_range(0, 3))
            0: stamp = stamp;
            1: stamp = stamp + 1;
            2: stamp = stamp + 86399;
            default: stamp = stamp - 1;
          endcase
        end
        8, 9: begin
          // year ends, leap day and december in a random four-year cycle
          day_no = int'(DaysPerQuad * $urandom_range(0, 33)
                        + day_in_quad[$urandom_range(0, day_in_quad.size() - 1)]);
          stamp = (longint'(day_no) - DaysToEpoch) * 86400 + $urandom_range(0, 86399);
        end
        default: stamp = longint'($urandom);
      endcase
      send_time(stamp[TimeWidth-1:0]);
    end
  endtask

  always @(posedge clk) begin
    cal_time_t got;
    cal_time_t want;
    if (rst_n && out_valid === 1'b1) begin
      got = '{out_second, out_minute, out_hour, out_day_of_month, out_month,
              out_years_since_1900, out_weekday, out_day_of_year};
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: %p", got);
      end else begin
        want = pending_dates.pop_front();
        n_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on transaction %0d", n_checked);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timed out with %0d transactions outstanding", pending_dates.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_day_boundaries();
    test_range_extremes();
    test_leap_and_december();
    test_random_times(RandomItems);
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    mismatches += pending_dates.size();
    $display("converted %0d timestamps, %0d of them before 1970, %0d on a leap-year 31 december",
             n_sent, n_before_epoch, n_leap_dec31);
    $display("%0d results compared, %0d errors", n_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
